FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masked
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, reset masked
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/casg_pkg.sv
`timescale 1ns / 1ps

package casg_pkg;

   localparam int BoardDim = 8;
   localparam int SqBits   = $clog2(BoardDim * BoardDim);
   localparam int CoordW   = $clog2(BoardDim);
   localparam int Dirs     = 8;
   localparam int RaySpan  = BoardDim - 1;

   localparam logic [1:0] KIND_KNIGHT = 2'd0;
   localparam logic [1:0] KIND_BISHOP = 2'd1;
   localparam logic [1:0] KIND_ROOK   = 2'd2;
   localparam logic [1:0] KIND_KING   = 2'd3;

   localparam logic signed [2:0] JUMP_DR [0:7] =
      '{-3'sd2, -3'sd1, 3'sd1, 3'sd2, 3'sd2, 3'sd1, -3'sd1, -3'sd2};
   localparam logic signed [2:0] JUMP_DF [0:7] =
      '{3'sd1, 3'sd2, 3'sd2, 3'sd1, -3'sd1, -3'sd2, -3'sd2, -3'sd1};
   localparam logic signed [2:0] NEAR_DR [0:7] =
      '{-3'sd1, -3'sd1, -3'sd1, 3'sd0, 3'sd0, 3'sd1, 3'sd1, 3'sd1};
   localparam logic signed [2:0] NEAR_DF [0:7] =
      '{-3'sd1, 3'sd0, 3'sd1, -3'sd1, 3'sd1, -3'sd1, 3'sd0, 3'sd1};
   localparam logic signed [2:0] DIAG_DR [0:3] = '{-3'sd1, 3'sd1, 3'sd1, -3'sd1};
   localparam logic signed [2:0] DIAG_DF [0:3] = '{3'sd1, 3'sd1, -3'sd1, -3'sd1};
   localparam logic signed [2:0] ORTH_DR [0:3] = '{-3'sd1, 3'sd0, 3'sd1, 3'sd0};
   localparam logic signed [2:0] ORTH_DF [0:3] = '{3'sd0, 3'sd1, 3'sd0, -3'sd1};

   typedef struct packed {
      logic [1:0]             kind;
      logic [CoordW-1:0]      rank;
      logic [CoordW-1:0]      file;
      logic [63:0]            occ;
      logic [63:0]            set;
      logic [Dirs-1:0]        alive;
   } item_type;

   function automatic logic is_slider(input logic [1:0] kind);
      return (kind == KIND_BISHOP) || (kind == KIND_ROOK);
   endfunction

   function automatic logic signed [2:0] dir_rank(input logic [1:0] kind,
                                                 input logic [2:0] idx);
      case (kind)
         KIND_KNIGHT: return JUMP_DR[idx];
         KIND_BISHOP: return DIAG_DR[idx[1:0]];
         KIND_ROOK:   return ORTH_DR[idx[1:0]];
         default:     return NEAR_DR[idx];
      endcase
   endfunction

   function automatic logic signed [2:0] dir_file(input logic [1:0] kind,
                                                 input logic [2:0] idx);
      case (kind)
         KIND_KNIGHT: return JUMP_DF[idx];
         KIND_BISHOP: return DIAG_DF[idx[1:0]];
         KIND_ROOK:   return ORTH_DF[idx[1:0]];
         default:     return NEAR_DF[idx];
      endcase
   endfunction

endpackage

FILE: rtl/core/casg_ray_cell.sv
`timescale 1ns / 1ps

// One ray step at a fixed distance for all directions still open.
module casg_ray_cell #(
   parameter int Dist = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  casg_pkg::item_type  in_item,
   output logic                in_stall,
   output logic                out_valid,
   output casg_pkg::item_type  out_item,
   input  logic                out_stall
);

   logic               valid_ff, valid_in;
   casg_pkg::item_type item_ff, item_in;
   logic               load;

   logic [5:0] rank_sum [casg_pkg::Dirs];
   logic [5:0] file_sum [casg_pkg::Dirs];

   assign in_stall = valid_ff && out_stall;
   assign load     = !in_stall;
   assign valid_in = load ? in_valid : valid_ff;

   always_comb begin
      logic [casg_pkg::SqBits-1:0] sq;
      logic                        hit;
      logic                        slide;
      item_in = in_item;
      slide   = casg_pkg::is_slider(in_item.kind);
      for (int i = 0; i < casg_pkg::Dirs; i++) begin
         // 6-bit wraparound arithmetic; off-board shows in the top three bits
         rank_sum[i] = {3'b000, in_item.rank}
                     + 6'(casg_pkg::dir_rank(in_item.kind, 3'(i))) * 6'(Dist);
         file_sum[i] = {3'b000, in_item.file}
                     + 6'(casg_pkg::dir_file(in_item.kind, 3'(i))) * 6'(Dist);
         hit = in_item.alive[i] && (rank_sum[i][5:3] == 3'b000)
            && (file_sum[i][5:3] == 3'b000);
         sq  = {rank_sum[i][2:0], file_sum[i][2:0]};
         if (hit) begin
            item_in.set[sq] = 1'b1;
         end
         // blocker is included, then the ray closes; jump/neighbor sets close at once
         item_in.alive[i] = hit && slide && !in_item.occ[sq];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: rtl/core/chess_attack_set_generator_core.sv
`timescale 1ns / 1ps

// Attack set generator: takes a piece kind, an origin square and a 64-bit
// occupancy board and returns the attacked squares. One query word enters per
// cycle unless stalled; each passes a chain of seven registered ray cells,
// cell k handling the squares at distance k along each direction still open.
// Stall ripples back through the chain, and empty cells keep loading, so gaps
// in the stream close up while the output is held.
`include "assert_macros.svh"

module chess_attack_set_generator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [5:0]  req_from_square,
   input  logic [63:0] req_occupancy,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_attack_set
);

   localparam int Cells = casg_pkg::RaySpan;

   logic               stage_valid [Cells+1];
   casg_pkg::item_type stage_item  [Cells+1];
   logic               stage_stall [Cells+1];
   logic [casg_pkg::SqBits-1:0] origin_sq;

   assign stage_valid[0]      = req_valid;
   assign stage_item[0].kind  = req_kind;
   assign stage_item[0].rank  = req_from_square[5:3];
   assign stage_item[0].file  = req_from_square[2:0];
   assign stage_item[0].occ   = req_occupancy;
   assign stage_item[0].set   = '0;
   // sliders use the four ray directions, step pieces all eight offsets
   assign stage_item[0].alive = casg_pkg::is_slider(req_kind) ? 8'h0F : 8'hFF;

   for (genvar g = 0; g < Cells; g++) begin : g_cell
      casg_ray_cell #(
         .Dist (g + 1)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_item   (stage_item[g]),
         .in_stall  (stage_stall[g]),
         .out_valid (stage_valid[g+1]),
         .out_item  (stage_item[g+1]),
         .out_stall (stage_stall[g+1])
      );
   end

   assign stage_stall[Cells] = rsp_stall;
   assign req_stall          = stage_stall[0];
   assign rsp_valid          = stage_valid[Cells];
   assign rsp_attack_set     = stage_item[Cells].set;

   assign origin_sq = {stage_item[Cells].rank, stage_item[Cells].file};

   `CHK_IMPL(a_origin_clear, clock, reset, rsp_valid, !rsp_attack_set[origin_sq], "origin square in attack set")
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_attack_set), "result word changed while stalled")
   `CHK_NEXT(a_entry, clock, reset, req_valid && !req_stall, stage_valid[1], "accepted word missing in first cell")
   `CHK_IMPL(a_step_once, clock, reset, stage_valid[1] && !casg_pkg::is_slider(stage_item[1].kind), stage_item[1].alive == 8'h00, "step piece left open after first cell")

endmodule
